// ===== design/b64d_pkg.sv =====
package b64d_pkg;

	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LO    = 8'h6F;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LY    = 8'h79;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PAD   = 8'h3D;

	typedef struct packed {
		logic       legal;
		logic [5:0] code;
	} sym_t;

	// One queued job expands into one to three result items.
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nres;
		logic        byte_valid;
		logic        bad;
		logic        last;
	} b64d_job_t;

	function automatic sym_t sym_decode(input logic [7:0] c);
		sym_t       s;
		logic [7:0] d;
		s.legal = 1'b1;
		d = 8'd0;
		case (c) inside
			[CH_K:CH_T]:   d = c - CH_K;
			[CH_A:CH_J]:   d = c - CH_A + 8'd10;
			[CH_U:CH_Z]:   d = c - CH_U + 8'd20;
			[CH_LA:CH_LD]: d = c - CH_LA + 8'd26;
			[CH_LO:CH_LX]: d = c - CH_LO + 8'd30;
			[CH_LE:CH_LN]: d = c - CH_LE + 8'd40;
			CH_LY:         d = 8'd50;
			CH_LZ:         d = 8'd51;
			[CH_0:CH_9]:   d = c - CH_0 + 8'd52;
			CH_PLUS:       d = 8'd62;
			CH_SLASH:      d = 8'd63;
			default:       s.legal = 1'b0;
		endcase
		s.code = d[5:0];
		return s;
	endfunction

endpackage

// ===== design/b64d_if.sv =====
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_text;

	modport source(output valid, output char_in, output end_of_text, input ready);
	modport sink(input valid, input char_in, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       bad_input;
	logic       last_out;

	modport source(output valid, output data_byte, output byte_valid, output bad_input,
		output last_out, input ready);
	modport sink(input valid, input data_byte, input byte_valid, input bad_input,
		input last_out, output ready);
endinterface

// ===== design/b64d_front.sv =====
module b64d_front
	import b64d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	b64d_char_if.sink       enc,
	input  logic            full,
	output logic            push,
	output b64d_job_t       job
);

	logic [17:0] acc_q;
	logic [1:0]  cnt_q;
	logic [17:0] acc_n;
	logic [1:0]  cnt_n;
	logic        accept;
	sym_t        sym;
	logic        eot;

	assign enc.ready = !full;
	assign accept    = enc.valid && !full;
	assign sym       = sym_decode(enc.char_in);
	assign eot       = enc.end_of_text;

	always_comb begin
		logic [17:0] acc_t;
		logic [1:0]  cnt_t;
		acc_t = acc_q;
		cnt_t = cnt_q;
		acc_n = acc_q;
		cnt_n = cnt_q;
		push  = 1'b0;
		job   = '0;
		if (enc.char_in != CH_PAD && !sym.legal) begin
			push     = 1'b1;
			job.nres = 2'd1;
			job.bad  = 1'b1;
			job.last = eot;
			if (eot) begin
				acc_n = '0;
				cnt_n = '0;
			end
		end else if (sym.legal && cnt_q == 2'd3) begin
			push           = 1'b1;
			job.word       = {acc_q, sym.code};
			job.nres       = 2'd3;
			job.byte_valid = 1'b1;
			job.last       = eot;
			acc_n          = '0;
			cnt_n          = '0;
		end else begin
			if (sym.legal) begin
				acc_t = {acc_q[11:0], sym.code};
				cnt_t = cnt_q + 2'd1;
			end
			acc_n = acc_t;
			cnt_n = cnt_t;
			if (eot) begin
				push     = 1'b1;
				job.last = 1'b1;
				job.nres = 2'd1;
				acc_n    = '0;
				cnt_n    = '0;
				case (cnt_t)
					2'd1: job.bad = 1'b1;
					2'd2: begin
						job.byte_valid = 1'b1;
						job.word       = {acc_t[11:4], 16'd0};
					end
					2'd3: begin
						job.byte_valid = 1'b1;
						job.nres       = 2'd2;
						job.word       = {acc_t[17:10], acc_t[9:2], 8'd0};
					end
					default: ;
				endcase
			end
		end
		if (!accept) begin
			push  = 1'b0;
			acc_n = acc_q;
			cnt_n = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			acc_q <= acc_n;
			cnt_q <= cnt_n;
		end
	end

`ifndef SYNTHESIS
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eot |=> cnt_q == 2'd0 && acc_q == 18'd0)
		else $error("pending group survived the end of the text");
`endif

endmodule

// ===== design/b64d_fifo.sv =====
module b64d_fifo
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  b64d_job_t wr_job,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output b64d_job_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_job_t      mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("job taken from an empty queue");
`endif

endmodule

// ===== design/b64d_back.sv =====
module b64d_back
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  b64d_job_t   head,
	output logic        pop,
	b64d_byte_if.source dec
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] data_q;
	logic       byte_valid_q;
	logic       bad_q;
	logic       last_q;
	logic       load;
	logic       final_res;
	logic [7:0] sel_byte;

	assign load      = head_valid && (!out_valid_q || dec.ready);
	assign final_res = idx_q == head.nres - 2'd1;
	assign pop       = load && final_res;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.word[23:16];
			2'd1:    sel_byte = head.word[15:8];
			default: sel_byte = head.word[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q       <= sel_byte;
			byte_valid_q <= head.byte_valid;
			bad_q        <= head.bad;
			last_q       <= head.last && final_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_res ? 2'd0 : idx_q + 2'd1;
			end else if (dec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dec.valid      = out_valid_q;
	assign dec.data_byte  = data_q;
	assign dec.byte_valid = byte_valid_q;
	assign dec.bad_input  = bad_q;
	assign dec.last_out   = last_q;

`ifndef SYNTHESIS
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid && idx_q < head.nres)
		else $error("result index runs past the current job");
	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !byte_valid_q |-> data_q == 8'd0)
		else $error("nonzero data on an item without a byte");
`endif

endmodule

// ===== design/base64_custom_alphabet_decoder.sv =====
// Channel   Role   Payload
// enc       sink   char_in[7:0], end_of_text
// dec       source data_byte[7:0], byte_valid, bad_input, last_out
//
// One character is taken per cycle while the job queue has room.
// Each result item is loaded into the output register from the job at the queue head once
// the register is free or taken; a complete group gives three items, so dec sets the sustained rate.
// Reset clears the symbol state, the queue count and the output valid flag; no clearing pass.
// A stall on dec fills the queue, and enc.ready drops only when it is full.
module base64_custom_alphabet_decoder
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	b64d_char_if.sink   enc,
	b64d_byte_if.source dec
);

	logic      full;
	logic      push;
	b64d_job_t wr_job;
	logic      pop;
	logic      head_valid;
	b64d_job_t head;

	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc),
		.full   (full),
		.push   (push),
		.job    (wr_job)
	);

	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (wr_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dec        (dec)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import b64d_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} char_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       bad_input;
		logic       last_out;
	} dec_result_t;

	logic clk = 1'b0;
	logic arst_n;

	b64d_char_if enc_ch();
	b64d_byte_if dec_ch();

	base64_custom_alphabet_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.enc(enc_ch),
		.dec(dec_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	string alphabet;
	logic [6:0] sym_of_char [256];

	char_item_t pending_chars[$];
	dec_result_t byte_expect[$];
	char_item_t next_char;

	logic [17:0] group_bits;
	logic [1:0] group_len;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sent_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int added_items = 0;
	int error_count = 0;
	int cycle_count = 0;

	task automatic push_result(input logic [7:0] b, input logic v, input logic bad,
		input logic last);
		dec_result_t r;
		r.data_byte = b;
		r.byte_valid = v;
		r.bad_input = bad;
		r.last_out = last;
		byte_expect.push_back(r);
	endtask

	task automatic decode_char(input logic [7:0] c, input logic eot);
		logic [6:0] s;
		logic [23:0] word;
		s = sym_of_char[c];
		if (c != CH_PAD) begin
			if (!s[6]) begin
				push_result(8'h00, 1'b0, 1'b1, eot);
				if (eot) begin
					group_bits = '0;
					group_len = '0;
				end
				return;
			end
			if (group_len == 2'd3) begin
				word = {group_bits, s[5:0]};
				push_result(word[23:16], 1'b1, 1'b0, 1'b0);
				push_result(word[15:8], 1'b1, 1'b0, 1'b0);
				push_result(word[7:0], 1'b1, 1'b0, eot);
				group_bits = '0;
				group_len = '0;
				return;
			end
			group_bits = {group_bits[11:0], s[5:0]};
			group_len = group_len + 2'd1;
		end
		if (!eot)
			return;
		case (group_len)
			2'd0: push_result(8'h00, 1'b0, 1'b0, 1'b1);
			2'd1: push_result(8'h00, 1'b0, 1'b1, 1'b1);
			2'd2: push_result(group_bits[11:4], 1'b1, 1'b0, 1'b1);
			default: begin
				push_result(group_bits[17:10], 1'b1, 1'b0, 1'b0);
				push_result(group_bits[9:2], 1'b1, 1'b0, 1'b1);
			end
		endcase
		group_bits = '0;
		group_len = '0;
	endtask

	task automatic push_item(input logic [7:0] c, input logic eot);
		char_item_t it;
		it.ch = c;
		it.eot = eot;
		pending_chars.push_back(it);
		added_items++;
	endtask

	task automatic push_str(input string s, input bit eot_last);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], eot_last && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] illegal_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (sym_of_char[c][6] || c == CH_PAD);
		return c;
	endfunction

	task automatic add_text(input int nsym, input int npad, input bit broken);
		int at;
		at = broken ? $urandom_range(nsym - 1) : -1;
		for (int i = 0; i < nsym; i++) begin
			if (i == at)
				push_item($urandom_range(1) ? illegal_char() : CH_PAD, 1'b0);
			push_item(alphabet[$urandom_range(63)], (i == nsym - 1) && (npad == 0));
		end
		for (int i = 0; i < npad; i++)
			push_item(CH_PAD, i == npad - 1);
	endtask

	task automatic add_random(input int count);
		int target;
		int roll;
		int r;
		int nsym;
		int n;
		target = added_items + count;
		while (added_items < target) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				case ($urandom_range(2))
					0: r = 0;
					1: r = 2;
					default: r = 3;
				endcase
				nsym = 4 * $urandom_range(3) + r;
				if (nsym == 0)
					nsym = 4;
				add_text(nsym, (r != 0 && $urandom_range(1)) ? 4 - r : 0, 1'b0);
			end else if (roll < 85) begin
				if ($urandom_range(1))
					add_text(4 * $urandom_range(2) + 1, $urandom_range(3), 1'b0);
				else
					add_text($urandom_range(1, 10), 0, 1'b1);
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					push_item(8'($urandom_range(255)), (i == n - 1) && $urandom_range(1));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_ch.valid <= 1'b0;
			enc_ch.char_in <= 8'h00;
			enc_ch.end_of_text <= 1'b0;
		end else begin
			if (enc_ch.valid && enc_ch.ready) begin
				decode_char(enc_ch.char_in, enc_ch.end_of_text);
				sent_count <= sent_count + 1;
			end
			if (!enc_ch.valid || enc_ch.ready) begin
				if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_char = pending_chars.pop_front();
					enc_ch.valid <= 1'b1;
					enc_ch.char_in <= next_char.ch;
					enc_ch.end_of_text <= next_char.eot;
				end else begin
					enc_ch.valid <= 1'b0;
				end
			end
		end
	end

	// The output is held off once, long enough for the internal queue to fill up.
	always @(posedge clk) begin
		if (!hold_done && sent_count == 12) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dec_ch.ready <= 1'b0;
		else
			dec_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		dec_result_t got;
		dec_result_t want;
		if (arst_n === 1'b1 && dec_ch.valid && dec_ch.ready) begin
			got.data_byte = dec_ch.data_byte;
			got.byte_valid = dec_ch.byte_valid;
			got.bad_input = dec_ch.bad_input;
			got.last_out = dec_ch.last_out;
			if (byte_expect.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected item: data_byte=%h byte_valid=%b bad_input=%b last_out=%b",
						got.data_byte, got.byte_valid, got.bad_input, got.last_out);
			end else begin
				want = byte_expect.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
							want.data_byte, want.byte_valid, want.bad_input, want.last_out,
							got.data_byte, got.byte_valid, got.bad_input, got.last_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		enc_ch.valid = 1'b0;
		enc_ch.char_in = 8'h00;
		enc_ch.end_of_text = 1'b0;
		dec_ch.ready = 1'b0;
		group_bits = '0;
		group_len = '0;
		alphabet = "KLMNOPQRSTABCDEFGHIJUVWXYZabcdopqrstuvwxefghijklmnyz0123456789+/";
		for (int i = 0; i < 256; i++)
			sym_of_char[i] = 7'd0;
		for (int i = 0; i < 64; i++)
			sym_of_char[alphabet[i]] = {1'b1, i[5:0]};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_str("KKKK////", 1'b1);
		push_str("AB==", 1'b1);
		push_str("ABC=", 1'b1);
		push_str("A", 1'b1);
		push_str("Kz", 1'b0);
		push_item(8'h00, 1'b0);
		push_str("9+", 1'b1);
		push_item(8'hFF, 1'b1);
		push_str("y", 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(CH_PAD, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			add_random(phase == 0 ? 95 : 120);
			// The sender pauses until every result of this phase has come back.
			do
				@(posedge clk);
			while (pending_chars.size() > 0 || enc_ch.valid || byte_expect.size() > 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && byte_expect.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
design/b64d_pkg.sv
design/b64d_if.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_custom_alphabet_decoder.sv
tb/tb.sv
